>>> sv/lcdn_pkg.sv
// Shared types and constants for the 4-bit character LCD interface.
// Holds request codes, controller command bytes and the config/result structs.
// No dependencies.
`default_nettype none

package lcdn_pkg;

    localparam int unsigned CMD_W = 3;

    // Request codes on the cmd field.
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_CMD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_DAT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INIT      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GOTO      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [1:0] CFG_SETTLE      = 2'd1;
    localparam logic [1:0] CFG_EXTRA       = 2'd2;

    // Controller command bytes.
    localparam logic [7:0] LINE0_BASE    = 8'h80;
    localparam logic [7:0] LINE1_BASE    = 8'hC0;
    localparam logic [7:0] CLEAR_BYTE    = 8'h01;
    localparam logic [2:0] INIT_REMAIN   = 3'd6;

    // Reset values of the timing registers.
    localparam logic [7:0] ENABLE_HIGH_RST = 8'd1;
    localparam logic [7:0] SETTLE_RST      = 8'd5;
    localparam logic [7:0] EXTRA_RST       = 8'd5;

    typedef struct packed {
        logic [7:0] enable_high_ticks;
        logic [7:0] settle_ticks;
        logic [7:0] extra_ticks;
    } cfg_t;

    typedef struct packed {
        logic       accepted;
        logic       busy_res;
        logic       reg_select;
        logic       enable;
        logic [3:0] data_nibble;
    } res_t;

    // Init sequence: 0x33,0x32,0x28,0x01,0x06,0x0C,0x02
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h0C;
            3'd6:    b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/lcdn_cfg.sv
// Timing configuration registers of the LCD interface.
// Depends on lcdn_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module lcdn_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [1:0]          wr_index,
    input  wire logic [7:0]          wr_data,
    output lcdn_pkg::cfg_t           cfg
);

    lcdn_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_high_ticks <= lcdn_pkg::ENABLE_HIGH_RST;
            cfg_reg.settle_ticks      <= lcdn_pkg::SETTLE_RST;
            cfg_reg.extra_ticks       <= lcdn_pkg::EXTRA_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lcdn_pkg::CFG_ENABLE_HIGH: cfg_reg.enable_high_ticks <= wr_data;
                lcdn_pkg::CFG_SETTLE:      cfg_reg.settle_ticks      <= wr_data;
                lcdn_pkg::CFG_EXTRA:       cfg_reg.extra_ticks       <= wr_data;
                default:                   ;  // drop writes past the list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/lcdn_seq.sv
// Transfer sequencer of the LCD interface: phase, counters and pin levels.
// Advances one tick per accepted beat; result is combinational for that tick.
// Depends on lcdn_pkg (codes, init table, cfg_t, res_t).
`default_nettype none

module lcdn_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic [2:0]          cmd,
    input  wire logic [7:0]          value,
    input  wire logic                row,
    input  wire logic [5:0]          column,
    input  wire lcdn_pkg::cfg_t      cfg,
    output lcdn_pkg::res_t           res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP_HI,
        PH_EN_HI,
        PH_SETUP_LO,
        PH_EN_LO,
        PH_SETTLE,
        PH_EXTRA
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [7:0] tick_reg,   tick_next;
    logic [7:0] byte_reg,   byte_next;
    logic       sel_reg,    sel_next;
    logic [2:0] init_reg,   init_next;
    logic       xpend_reg,  xpend_next;
    logic       pin_en_reg, pin_en_next;
    logic [3:0] pin_d_reg,  pin_d_next;

    logic       request;
    logic       accepted;
    logic [7:0] tick_inc;
    logic [7:0] en_lim;
    logic       fin_low;
    logic       fin_byte;
    logic [7:0] line_base;

    assign request   = (cmd inside {[lcdn_pkg::CMD_WRITE_CMD:lcdn_pkg::CMD_CLEAR]});
    assign tick_inc  = tick_reg + 8'd1;
    assign en_lim    = (cfg.enable_high_ticks == 8'd0) ? 8'd1 : cfg.enable_high_ticks;
    assign line_base = row ? lcdn_pkg::LINE1_BASE : lcdn_pkg::LINE0_BASE;

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        byte_next   = byte_reg;
        sel_next    = sel_reg;
        init_next   = init_reg;
        xpend_next  = xpend_reg;
        pin_en_next = pin_en_reg;
        pin_d_next  = pin_d_reg;
        accepted    = 1'b0;
        fin_low     = 1'b0;
        fin_byte    = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                pin_en_next = 1'b0;
                if (request)
                begin
                    accepted   = 1'b1;
                    sel_next   = 1'b0;
                    init_next  = 3'd0;
                    xpend_next = 1'b0;
                    case (cmd)
                        lcdn_pkg::CMD_WRITE_CMD: byte_next = value;
                        lcdn_pkg::CMD_WRITE_DAT:
                        begin
                            byte_next = value;
                            sel_next  = 1'b1;
                        end
                        lcdn_pkg::CMD_INIT:
                        begin
                            byte_next  = lcdn_pkg::init_byte(3'd0);
                            init_next  = lcdn_pkg::INIT_REMAIN;
                            xpend_next = 1'b1;
                        end
                        lcdn_pkg::CMD_GOTO:
                        begin
                            byte_next  = line_base + {2'b00, column};
                            xpend_next = 1'b1;
                        end
                        default:
                        begin
                            byte_next  = lcdn_pkg::CLEAR_BYTE;
                            xpend_next = 1'b1;
                        end
                    endcase
                    pin_d_next = byte_next[7:4];
                    tick_next  = 8'd0;
                    phase_next = PH_EN_HI;
                end
            end
            PH_SETUP_HI:
            begin
                pin_en_next = 1'b0;
                pin_d_next  = byte_reg[7:4];
                tick_next   = 8'd0;
                phase_next  = PH_EN_HI;
            end
            PH_EN_HI:
            begin
                pin_d_next  = byte_reg[7:4];
                pin_en_next = 1'b1;
                tick_next   = tick_inc;
                if (tick_inc >= en_lim)
                begin
                    tick_next  = 8'd0;
                    phase_next = PH_SETUP_LO;
                end
            end
            PH_SETUP_LO:
            begin
                pin_en_next = 1'b0;
                pin_d_next  = byte_reg[3:0];
                tick_next   = 8'd0;
                phase_next  = PH_EN_LO;
            end
            PH_EN_LO:
            begin
                pin_d_next  = byte_reg[3:0];
                pin_en_next = 1'b1;
                tick_next   = tick_inc;
                if (tick_inc >= en_lim)
                begin
                    fin_low = 1'b1;
                end
            end
            PH_SETTLE:
            begin
                pin_en_next = 1'b0;
                tick_next   = tick_inc;
                if (tick_inc >= cfg.settle_ticks)
                begin
                    fin_byte = 1'b1;
                end
            end
            PH_EXTRA:
            begin
                pin_en_next = 1'b0;
                tick_next   = tick_inc;
                if (tick_inc >= cfg.extra_ticks)
                begin
                    tick_next  = 8'd0;
                    xpend_next = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                pin_en_next = 1'b0;
                tick_next   = 8'd0;
                phase_next  = PH_IDLE;
            end
        endcase

        // Low nibble done: settle, or go straight to the end-of-byte step.
        if (fin_low)
        begin
            tick_next = 8'd0;
            if (cfg.settle_ticks != 8'd0)
                phase_next = PH_SETTLE;
            else
                fin_byte = 1'b1;
        end

        // End of byte: next init byte, extra delay, or back to idle.
        if (fin_byte)
        begin
            tick_next = 8'd0;
            if (init_reg != 3'd0 && init_reg <= lcdn_pkg::INIT_REMAIN)
            begin
                byte_next  = lcdn_pkg::init_byte(3'(3'd7 - init_reg));
                init_next  = init_reg - 3'd1;
                phase_next = PH_SETUP_HI;
            end
            else
            begin
                init_next = 3'd0;
                if (xpend_reg && cfg.extra_ticks != 8'd0)
                    phase_next = PH_EXTRA;
                else
                begin
                    xpend_next = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    assign res.accepted    = accepted;
    assign res.busy_res    = (phase_reg != PH_IDLE) || accepted;
    assign res.reg_select  = sel_next;
    assign res.enable      = pin_en_next;
    assign res.data_nibble = pin_d_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= 8'd0;
            byte_reg   <= 8'd0;
            sel_reg    <= 1'b0;
            init_reg   <= 3'd0;
            xpend_reg  <= 1'b0;
            pin_en_reg <= 1'b0;
            pin_d_reg  <= 4'd0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            byte_reg   <= byte_next;
            sel_reg    <= sel_next;
            init_reg   <= init_next;
            xpend_reg  <= xpend_next;
            pin_en_reg <= pin_en_next;
            pin_d_reg  <= pin_d_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/char_lcd_nibble_interface_unit.sv
// Top level of the 4-bit character LCD interface.
// Depends on lcdn_pkg, lcdn_cfg and lcdn_seq.
//
// Usage:
//   Each input beat (cmd, value, row, column) is one interface tick. cmd 0 is
//   a plain tick; codes 1..5 request write command, write data, init, goto
//   and clear. A request is taken only when the sequencer is idle; otherwise
//   it is refused (accepted 0, busy_res 1) and the running transfer goes on.
//   Every input beat yields exactly one result beat carrying accepted,
//   busy_res and the RS, E and D7..D4 pin levels for that tick.
//   The result beat is registered: it is ready in the cycle after its input
//   beat is taken. Throughput: one beat per cycle unless a result is stalled;
//   the sequencer step is a single pass of logic from state to result register.
//   Output stall: the result register holds its beat; in_stall rises only
//   while a result is held and out_stall is high, so a new beat is taken in
//   the same cycle the held one leaves.
//   Config port: cfg_ready is always high; index 0 enable-high ticks,
//   1 settle ticks, 2 extra ticks; other indexes are ignored. Write only
//   while idle.
//   Reset: sequencer idle, pins low, no result pending, timing registers at
//   enable 1, settle 5, extra 5.
`default_nettype none

module char_lcd_nibble_interface_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // request channel
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  value,
    input  wire logic        row,
    input  wire logic [5:0]  column,
    // result channel
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        accepted,
    output      logic        busy_res,
    output      logic        reg_select,
    output      logic        enable,
    output      logic [3:0]  data_nibble
);

    lcdn_pkg::cfg_t cfg;
    lcdn_pkg::res_t step_res;
    lcdn_pkg::res_t res_reg;
    logic           out_valid_reg, out_valid_next;
    logic           in_take;

    // Config writes are always taken.
    assign cfg_ready = 1'b1;

    lcdn_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Hold input only while a result sits in the register and is stalled.
    assign in_stall = out_valid_reg & out_stall;
    assign in_take  = in_valid & ~in_stall;

    lcdn_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (in_take),
        .cmd    (cmd),
        .value  (value),
        .row    (row),
        .column (column),
        .cfg    (cfg),
        .res    (step_res)
    );

    // Result register: load on a taken beat, drop once delivered.
    always_comb
    begin
        if (in_take)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            res_reg <= step_res;
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = res_reg.accepted;
    assign busy_res    = res_reg.busy_res;
    assign reg_select  = res_reg.reg_select;
    assign enable      = res_reg.enable;
    assign data_nibble = res_reg.data_nibble;

endmodule

`default_nettype wire

>>> tb/sv/lcdn_bus_checker.sv
// Scoreboard for the 4-bit character LCD interface: watches the config, request
// and result channels, predicts the pin levels of every tick and compares them.
// Depends on lcdn_pkg for request codes, register indexes and result types.
module lcdn_bus_checker
    import lcdn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [7:0] value,
    input  logic       row,
    input  logic [5:0] column,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       accepted,
    input  logic       busy_res,
    input  logic       reg_select,
    input  logic       enable,
    input  logic [3:0] data_nibble,
    output int         mismatches,
    output int         results_owed,
    output logic       seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INIT_LEN = 7;
    localparam logic [0:INIT_LEN-1][7:0] INIT_SEQ =
        {8'h33, 8'h32, 8'h28, 8'h01, 8'h06, 8'h0C, 8'h02};

    typedef enum logic [2:0] {
        BUS_IDLE, BUS_SETUP_HI, BUS_EN_HI, BUS_SETUP_LO, BUS_EN_LO, BUS_SETTLE, BUS_EXTRA
    } bus_phase_t;

    cfg_t       timing;
    bus_phase_t ph;
    logic [7:0] tick_cnt;
    logic [7:0] cur_byte;
    logic       rs_lvl;
    logic [2:0] init_left;
    logic       extra_due;
    logic       pin_en;
    logic [3:0] pin_d;
    res_t       pin_q[$];

    // Byte done: chain the next init byte, else fall into the extra delay or idle.
    task automatic close_byte();
        tick_cnt = '0;
        if (init_left != 3'd0)
        begin
            cur_byte  = INIT_SEQ[INIT_LEN - init_left];
            init_left = init_left - 3'd1;
            ph        = BUS_SETUP_HI;
        end
        else if (extra_due && timing.extra_ticks != 8'd0)
        begin
            ph = BUS_EXTRA;
        end
        else
        begin
            extra_due = 1'b0;
            ph        = BUS_IDLE;
        end
    endtask

    task automatic step_lcd_bus(input logic [2:0] c, input logic [7:0] v, input logic r,
                                input logic [5:0] col, output res_t res);
        logic [7:0] en_lim;
        logic       took;
        logic       busy;
        en_lim = (timing.enable_high_ticks == 8'd0) ? 8'd1 : timing.enable_high_ticks;
        took   = 1'b0;
        busy   = (ph != BUS_IDLE);
        case (ph)
            BUS_IDLE:
            begin
                if (c >= CMD_WRITE_CMD && c <= CMD_CLEAR)
                begin
                    took      = 1'b1;
                    busy      = 1'b1;
                    rs_lvl    = 1'b0;
                    init_left = '0;
                    extra_due = 1'b0;
                    case (c)
                        CMD_WRITE_CMD: cur_byte = v;
                        CMD_WRITE_DAT:
                        begin
                            cur_byte = v;
                            rs_lvl   = 1'b1;
                        end
                        CMD_INIT:
                        begin
                            cur_byte  = INIT_SEQ[0];
                            init_left = INIT_REMAIN;
                            extra_due = 1'b1;
                        end
                        CMD_GOTO:
                        begin
                            cur_byte  = (r ? LINE1_BASE : LINE0_BASE) + {2'b00, col};
                            extra_due = 1'b1;
                        end
                        default:
                        begin
                            cur_byte  = CLEAR_BYTE;
                            extra_due = 1'b1;
                        end
                    endcase
                    // the request tick itself is the high-nibble setup
                    pin_en   = 1'b0;
                    pin_d    = cur_byte[7:4];
                    tick_cnt = '0;
                    ph       = BUS_EN_HI;
                end
                else
                begin
                    pin_en = 1'b0;
                end
            end
            BUS_SETUP_HI:
            begin
                pin_en   = 1'b0;
                pin_d    = cur_byte[7:4];
                tick_cnt = '0;
                ph       = BUS_EN_HI;
            end
            BUS_EN_HI:
            begin
                pin_d    = cur_byte[7:4];
                pin_en   = 1'b1;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= en_lim)
                begin
                    tick_cnt = '0;
                    ph       = BUS_SETUP_LO;
                end
            end
            BUS_SETUP_LO:
            begin
                pin_en   = 1'b0;
                pin_d    = cur_byte[3:0];
                tick_cnt = '0;
                ph       = BUS_EN_LO;
            end
            BUS_EN_LO:
            begin
                pin_d    = cur_byte[3:0];
                pin_en   = 1'b1;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= en_lim)
                begin
                    tick_cnt = '0;
                    if (timing.settle_ticks != 8'd0)
                        ph = BUS_SETTLE;
                    else
                        close_byte();
                end
            end
            BUS_SETTLE:
            begin
                pin_en   = 1'b0;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= timing.settle_ticks)
                    close_byte();
            end
            BUS_EXTRA:
            begin
                pin_en   = 1'b0;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= timing.extra_ticks)
                begin
                    tick_cnt  = '0;
                    extra_due = 1'b0;
                    ph        = BUS_IDLE;
                end
            end
            default:
            begin
                pin_en   = 1'b0;
                tick_cnt = '0;
                ph       = BUS_IDLE;
            end
        endcase
        res.accepted    = took;
        res.busy_res    = busy;
        res.reg_select  = rs_lvl;
        res.enable      = pin_en;
        res.data_nibble = pin_d;
    endtask

    task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            timing.enable_high_ticks = ENABLE_HIGH_RST;
            timing.settle_ticks      = SETTLE_RST;
            timing.extra_ticks       = EXTRA_RST;
            ph           = BUS_IDLE;
            tick_cnt     = '0;
            cur_byte     = '0;
            rs_lvl       = 1'b0;
            init_left    = '0;
            extra_due    = 1'b0;
            pin_en       = 1'b0;
            pin_d        = '0;
            pin_q.delete();
            mismatches   = 0;
            results_owed = 0;
            seq_idle     = 1'b1;
        end
        else
        begin
            // retire the result beat before queueing this edge's request beat
            if (out_valid && !out_stall)
            begin
                if (pin_q.size() == 0)
                begin
                    $display("%0t ns: result expected none got %0b%0b%0b%0b/%0h", $time,
                             accepted, busy_res, reg_select, enable, data_nibble);
                    mismatches++;
                end
                else
                begin
                    want = pin_q.pop_front();
                    check_field("accepted", want.accepted, accepted);
                    check_field("busy_res", want.busy_res, busy_res);
                    check_field("reg_select", want.reg_select, reg_select);
                    check_field("enable", want.enable, enable);
                    check_field("data_nibble", want.data_nibble, data_nibble);
                end
            end
            if (in_valid && !in_stall)
            begin
                step_lcd_bus(cmd, value, row, column, want);
                pin_q.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE_HIGH: timing.enable_high_ticks = cfg_data;
                    CFG_SETTLE:      timing.settle_ticks      = cfg_data;
                    CFG_EXTRA:       timing.extra_ticks       = cfg_data;
                    default: ;
                endcase
            end
            results_owed = pin_q.size();
            seq_idle     = (ph == BUS_IDLE);
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the LCD nibble interface bench: clock, reset, request and config stimulus,
// receiver stall pattern and the verdict.
// Depends on lcdn_pkg, char_lcd_nibble_interface_unit and lcdn_bus_checker.
module tb_top;
    import lcdn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // cmd codes past clear are spare; the block treats them as a plain tick
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    // register index with no register behind it
    localparam logic [1:0] CFG_NONE     = 2'd3;
    localparam int         HOLD_CYCLES  = 300;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index   = CFG_ENABLE_HIGH;
    logic [7:0] cfg_data    = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [2:0] cmd         = CMD_TICK;
    logic [7:0] value       = '0;
    logic       row         = 1'b0;
    logic [5:0] column      = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic       accepted;
    logic       busy_res;
    logic       reg_select;
    logic       enable;
    logic [3:0] data_nibble;

    int   mismatches;
    int   results_owed;
    logic seq_idle;
    int   burst_left = 0;
    bit   bulk_on    = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    char_lcd_nibble_interface_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .row         (row),
        .column      (column),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .busy_res    (busy_res),
        .reg_select  (reg_select),
        .enable      (enable),
        .data_nibble (data_nibble)
    );

    lcdn_bus_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .row          (row),
        .column       (column),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .busy_res     (busy_res),
        .reg_select   (reg_select),
        .enable       (enable),
        .data_nibble  (data_nibble),
        .mismatches   (mismatches),
        .results_owed (results_owed),
        .seq_idle     (seq_idle)
    );

    // Offer one request beat and return at the edge that takes it. The sender runs in
    // bursts: at the start of a burst, most of the time drop valid for a random pause.
    // Valid stays high on return so a following beat can go out back to back; whoever
    // pauses afterwards must drop it in a later step.
    task automatic send_beat(input logic [2:0] c, input logic [7:0] v, input logic r,
                             input logic [5:0] col);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 9) < 7)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        cmd      <= c;
        value    <= v;
        row      <= r;
        column   <= col;
        in_valid <= 1'b1;
        // stall is settled by the falling edge and holds until the next rising one
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    // Plain tick with a random payload, so the ignored fields still toggle.
    task automatic send_tick();
        send_beat(CMD_TICK, 8'($urandom), 1'($urandom), 6'($urandom));
    endtask

    task automatic send_request();
        logic [2:0] c;
        c = 3'($urandom_range(CMD_CLEAR, CMD_WRITE_CMD));
        send_beat(c, 8'($urandom), 1'($urandom), 6'($urandom));
    endtask

    // Tick the sequencer until the predicted phase is idle. Valid is dropped while the
    // scoreboard state is read at the falling edge, so no beat slips in unseen.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (!seq_idle)
        begin
            @(posedge clk);
            send_tick();
            in_valid <= 1'b0;
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Request on the very first tick after the last delay tick.
    task automatic issue(input logic [2:0] c, input logic [7:0] v, input logic r,
                         input logic [5:0] col);
        wait_idle();
        send_beat(c, v, r, col);
    endtask

    task automatic wait_results();
        @(negedge clk);
        while (results_owed != 0) @(negedge clk);
    endtask

    // Bring the block to rest before touching the timing registers.
    task automatic quiesce();
        wait_idle();
        wait_results();
        repeat (3) @(posedge clk);
    endtask

    // Write all three timing registers plus the unmapped index, back to back.
    task automatic program_timing(input logic [7:0] en_t, input logic [7:0] st_t,
                                  input logic [7:0] ex_t);
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0:
                begin
                    cfg_index <= CFG_ENABLE_HIGH;
                    cfg_data  <= en_t;
                end
                1:
                begin
                    cfg_index <= CFG_SETTLE;
                    cfg_data  <= st_t;
                end
                2:
                begin
                    cfg_index <= CFG_EXTRA;
                    cfg_data  <= ex_t;
                end
                default:
                begin
                    cfg_index <= CFG_NONE;
                    cfg_data  <= 8'($urandom);
                end
            endcase
            cfg_valid <= 1'b1;
            @(negedge clk);
            while (!cfg_ready) @(negedge clk);
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly requests timed to land right as the sequencer frees up,
    // some fired after a random number of ticks (often refused), and some noise.
    task automatic run_mix(input int n_req);
        int pick;
        for (int i = 0; i < n_req; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                wait_idle();
                repeat ($urandom_range(0, 2)) send_tick();
                send_request();
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(0, 12)) send_tick();
                send_request();
            end
            else if (pick < 92)
            begin
                send_beat($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
                          8'($urandom), 1'($urandom), 6'($urandom));
            end
            else
            begin
                // back-to-back requests: at most one is taken, the others hit a busy sequencer
                repeat (3) send_request();
            end
        end
    endtask

    // Receiver: stall in segments of random style and length. Once the bulk traffic
    // is running, hold off for a long stretch so the result register fills and the
    // block pushes back on the request channel.
    initial
    begin : receiver
        int  span;
        int  style;
        bit  hold_done;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (bulk_on && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(8, 80);
                // cut the segment short once bulk traffic starts, so the hold meets it
                for (int k = 0; k < span && !(bulk_on && !hold_done); k++)
                begin
                    case (style)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 99) < 30);
                        2:       out_stall <= ((k % 5) >= 3);
                        default: out_stall <= ($urandom_range(0, 99) < 75);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] en_t;
        logic [7:0] st_t;
        logic [7:0] ex_t;
        int         n_req;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset timing (enable 1, settle 5, extra 5).
        // Ticks while idle: pins hold, nothing taken.
        send_beat(CMD_TICK, 8'hFF, 1'b1, 6'h3F);
        send_beat(CMD_TICK, 8'h00, 1'b0, 6'h00);
        // Byte extremes on both register selects.
        issue(CMD_WRITE_CMD, 8'h00, 1'b0, 6'h00);
        issue(CMD_WRITE_CMD, 8'hFF, 1'b1, 6'h3F);
        issue(CMD_WRITE_DAT, 8'hFF, 1'b0, 6'h00);
        issue(CMD_WRITE_DAT, 8'h00, 1'b1, 6'h3F);
        issue(CMD_WRITE_DAT, 8'hA5, 1'b0, 6'h15);
        // Full init chain, then goto at both lines and both column extremes, then clear.
        issue(CMD_INIT, 8'h5A, 1'b1, 6'h2A);
        issue(CMD_GOTO, 8'h00, 1'b0, 6'h00);
        issue(CMD_GOTO, 8'hFF, 1'b1, 6'h3F);
        issue(CMD_GOTO, 8'h00, 1'b0, 6'h3F);
        issue(CMD_GOTO, 8'hFF, 1'b1, 6'h00);
        issue(CMD_CLEAR, 8'h81, 1'b1, 6'h21);
        // Spare codes act as ticks.
        issue(CMD_SPARE_LO, 8'h3C, 1'b0, 6'h0F);
        issue(CMD_SPARE_HI, 8'hC3, 1'b1, 6'h30);
        // Requests while busy are refused; the running transfer goes on.
        issue(CMD_WRITE_DAT, 8'h5A, 1'b0, 6'h00);
        send_beat(CMD_CLEAR, 8'h00, 1'b0, 6'h00);
        send_beat(CMD_INIT, 8'h00, 1'b0, 6'h00);
        send_beat(CMD_GOTO, 8'h00, 1'b1, 6'h07);
        // Request on the tick right after the last delay tick is taken.
        issue(CMD_WRITE_CMD, 8'h3C, 1'b0, 6'h00);

        // Timing sweeps: zero (enable treated as one, delays skipped), ones, mid values,
        // a zero settle, a zero extra and a random mix; request counts keep the whole
        // run near 650 beats.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    en_t = 8'd0;   st_t = 8'd0;   ex_t = 8'd0;   n_req = 10;
                end
                1:
                begin
                    en_t = 8'd1;   st_t = 8'd1;   ex_t = 8'd1;   n_req = 6;
                end
                2:
                begin
                    en_t = 8'd3;   st_t = 8'd2;   ex_t = 8'd7;   n_req = 4;
                end
                3:
                begin
                    en_t = 8'd2;   st_t = 8'd0;   ex_t = 8'd4;   n_req = 4;
                end
                4:
                begin
                    en_t = 8'd5;   st_t = 8'd1;   ex_t = 8'd0;   n_req = 2;
                end
                default:
                begin
                    en_t  = 8'($urandom_range(1, 4));
                    st_t  = 8'($urandom_range(0, 4));
                    ex_t  = 8'($urandom_range(0, 4));
                    n_req = 3;
                end
            endcase
            quiesce();
            program_timing(en_t, st_t, ex_t);
            bulk_on = 1'b1;
            run_mix(n_req);
        end

        // Drain: everything offered has been taken; wait for the last results.
        in_valid <= 1'b0;
        wait_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin : watchdog
        #1ms;
        $display("status: fail");
        $finish;
    end

endmodule
